// ----- sv/rrs_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helpers of the round-robin slice scheduler.
// Depends on nothing; used by the scheduler top level and the bench files.
package rrs_pkg;

  // Default size of the job table.
  localparam int unsigned MAX_JOBS_DEF = 64;

  localparam int unsigned BURST_W   = 24;
  localparam int unsigned SLICE_W   = 16;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned JOB_ID_W  = 7;
  localparam int unsigned ENTRY_W   = BURST_W + SLICE_W;
  localparam int unsigned IN_DATA_W = 24;
  localparam int unsigned OUT_DATA_W = 120;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SWITCH_COST = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPACING     = 2'd2;

  localparam logic [CFG_W-1:0] QUANTUM_RST     = 16'd50;
  localparam logic [CFG_W-1:0] SWITCH_COST_RST = 16'd10;
  localparam logic [CFG_W-1:0] SPACING_RST     = 16'd50;

  // Item kinds carried on tuser.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  // Result item; job_id sits in the lowest bits.
  typedef struct packed {
    logic [SLICE_W-1:0]  switch_total;
    logic                all_done;
    logic                finished;
    logic                switched;
    logic [31:0]         elapsed;
    logic [31:0]         wait_time;
    logic [BURST_W-1:0]  cycles_left;
    logic [JOB_ID_W-1:0] job_id;
  } result_t;

  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

// ----- sv/rrs_job_mem.sv -----
`timescale 1ns / 1ps
// Job table: one write port and one read port, read data registered.
// Depends on nothing; instantiated by the scheduler top level.
module rrs_job_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6,
  parameter int unsigned DW    = 40
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/rrs_pick.sv -----
`timescale 1ns / 1ps
// Next-job search: first set bit of the active mask at or after the start
// index, wrapping round to the bottom. No package dependency.
module rrs_pick #(
  parameter int unsigned MAX_JOBS = 64,
  parameter int unsigned IDX_W    = 6
) (
  input  logic [MAX_JOBS-1:0] mask_i,
  input  logic [IDX_W-1:0]    start_i,
  output logic                found_o,
  output logic [IDX_W-1:0]    idx_o
);

  logic [MAX_JOBS-1:0] upper;
  logic [IDX_W-1:0]    upper_idx;
  logic [IDX_W-1:0]    any_idx;

  // Bits at or above the start index; bits beyond the loaded count are
  // always clear, so no upper bound is needed.
  always_comb begin
    for (int unsigned i = 0; i < MAX_JOBS; i++) begin
      upper[i] = mask_i[i] && (i >= 32'(start_i));
    end
  end

  always_comb begin
    upper_idx = '0;
    any_idx   = '0;
    for (int i = MAX_JOBS - 1; i >= 0; i--) begin
      if (upper[i]) begin
        upper_idx = IDX_W'(i);
      end
      if (mask_i[i]) begin
        any_idx = IDX_W'(i);
      end
    end
  end

  assign found_o = |mask_i;
  assign idx_o   = (|upper) ? upper_idx : any_idx;

endmodule

// ----- sv/round_robin_slice_scheduler.sv -----
`timescale 1ns / 1ps
// Round-robin slice scheduler top level: control sequence, job state and ports.
// Depends on rrs_pkg, rrs_job_mem and rrs_pick.

// Items with tuser low load one job burst into the table (tlast closes the set) and give
// no result; the scheduler stays idle. Items with tuser high serve one slice of the next
// unfinished job after the one last served and give one result item. A served slice goes
// through the accept cycle, which picks the job from the active mask and reads its table
// entry, the multiply state, which forms the arrival and served-time products, and
// the finish state, which writes the entry back and loads the output once it is free.
// A step with no unfinished job goes to the empty state. The table entry read and its
// write-back belong to one item and items are handled one at a time, so table accesses
// never overlap. A new item is accepted while a result still waits on the output.
module round_robin_slice_scheduler #(
  parameter int unsigned MAX_JOBS = rrs_pkg::MAX_JOBS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration write port.
  input  logic                            cfg_we_i,
  input  logic [rrs_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [rrs_pkg::CFG_W-1:0]       cfg_wdata_i,
  // Input stream.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [rrs_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // [23:0] burst
  input  logic                            s_axis_tuser,  // [0] cmd
  input  logic                            s_axis_tlast,  // load_last
  // Result stream.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [6:0] job_id, [30:7] cycles_left, [62:31] wait_time, [94:63] elapsed,
  // [95] switched, [96] finished, [97] all_done, [113:98] switch_total,
  // [119:114] zero
  output logic [rrs_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

  localparam int unsigned IDX_W   = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int unsigned CNT_W   = $clog2(MAX_JOBS + 1);
  localparam int unsigned PARR_W  = IDX_W + rrs_pkg::CFG_W;
  localparam int unsigned DIFF_W  = 35;
  localparam int unsigned RES_W   = $bits(rrs_pkg::result_t);

  localparam logic signed [DIFF_W-1:0] WAIT_MAX = 35'sh7FFF_FFFF;
  localparam logic signed [DIFF_W-1:0] WAIT_MIN = -35'sh8000_0000;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_MUL   = 2'd1;
  localparam logic [1:0] ST_FIN   = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  // Configuration registers.
  logic [rrs_pkg::CFG_W-1:0] quantum_q, switch_cost_q, spacing_q;

  // Scheduler state.
  logic [1:0]                  state_q, state_d;
  logic [MAX_JOBS-1:0]         mask_q, mask_d;
  logic [CNT_W-1:0]            job_count_q, job_count_d;
  logic [IDX_W-1:0]            next_index_q, next_index_d;
  logic [IDX_W-1:0]            last_served_q, last_served_d;
  logic [31:0]                 time_q, time_d;
  logic [rrs_pkg::SLICE_W-1:0] switch_count_q, switch_count_d;
  logic                        load_open_q, load_open_d;

  // Per-slice working registers.
  logic [IDX_W-1:0]            idx_q, idx_d;
  logic [rrs_pkg::BURST_W-1:0] rem_q, rem_d;
  logic [rrs_pkg::SLICE_W-1:0] srv_q, srv_d;
  logic [rrs_pkg::CFG_W-1:0]   qeff_q, qeff_d;
  logic [PARR_W-1:0]           parr_q, parr_d;
  logic [31:0]                 psrv_q, psrv_d;
  logic                        sw_q, sw_d;

  // Output register.
  logic                        out_valid_q, out_valid_d;
  rrs_pkg::result_t            res_q, res_d;

  // Table ports.
  logic                        mem_we, mem_re;
  logic [IDX_W-1:0]            mem_waddr;
  logic [rrs_pkg::ENTRY_W-1:0] mem_wdata, mem_rdata;

  logic             pick_found;
  logic [IDX_W-1:0] pick_idx;

  logic                        in_fire, out_free;
  logic [CNT_W-1:0]            base_count;
  logic                        sw_now;
  logic [32:0]                 sub_sum;
  logic signed [DIFF_W-1:0]    diff;
  logic [31:0]                 wait_sat;
  logic [rrs_pkg::BURST_W-1:0] run, left;
  logic                        fin;
  logic [MAX_JOBS-1:0]         mask_after;
  logic [CNT_W-1:0]            idx_inc;
  logic [31:0]                 id_ext;

  rrs_job_mem #(
    .DEPTH (MAX_JOBS),
    .AW    (IDX_W),
    .DW    (rrs_pkg::ENTRY_W)
  ) u_job_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (pick_idx),
    .rdata_o (mem_rdata)
  );

  rrs_pick #(
    .MAX_JOBS (MAX_JOBS),
    .IDX_W    (IDX_W)
  ) u_pick (
    .mask_i  (mask_q),
    .start_i (next_index_q),
    .found_o (pick_found),
    .idx_o   (pick_idx)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(rrs_pkg::OUT_DATA_W - RES_W)'(0), res_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quantum_q     <= rrs_pkg::QUANTUM_RST;
      switch_cost_q <= rrs_pkg::SWITCH_COST_RST;
      spacing_q     <= rrs_pkg::SPACING_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == rrs_pkg::CFG_QUANTUM) begin
        quantum_q <= cfg_wdata_i;
      end
      if (cfg_idx_i == rrs_pkg::CFG_SWITCH_COST) begin
        switch_cost_q <= cfg_wdata_i;
      end
      if (cfg_idx_i == rrs_pkg::CFG_SPACING) begin
        spacing_q <= cfg_wdata_i;
      end
    end
  end

  // Slice arithmetic for the write-back cycle.
  always_comb begin
    sub_sum  = 33'(parr_q) + 33'(psrv_q);
    diff     = $signed({3'b000, time_q}) - $signed({2'b00, sub_sum});
    if (diff > WAIT_MAX) begin
      wait_sat = WAIT_MAX[31:0];
    end else if (diff < WAIT_MIN) begin
      wait_sat = WAIT_MIN[31:0];
    end else begin
      wait_sat = diff[31:0];
    end
    run        = (rem_q > rrs_pkg::BURST_W'(qeff_q)) ? rrs_pkg::BURST_W'(qeff_q) : rem_q;
    left       = rem_q - run;
    fin        = (left == '0);
    mask_after = mask_q;
    if (fin) begin
      mask_after[idx_q] = 1'b0;
    end
    idx_inc = CNT_W'(idx_q) + CNT_W'(1);
    id_ext  = 32'(idx_q) + 32'd1;
  end

  always_comb begin
    state_d        = state_q;
    mask_d         = mask_q;
    job_count_d    = job_count_q;
    next_index_d   = next_index_q;
    last_served_d  = last_served_q;
    time_d         = time_q;
    switch_count_d = switch_count_q;
    load_open_d    = load_open_q;
    idx_d          = idx_q;
    rem_d          = rem_q;
    srv_d          = srv_q;
    qeff_d         = qeff_q;
    parr_d         = parr_q;
    psrv_d         = psrv_q;
    sw_d           = sw_q;
    out_valid_d    = out_valid_q && !m_axis_tready;
    res_d          = res_q;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_waddr      = idx_q;
    mem_wdata      = '0;
    base_count     = load_open_q ? job_count_q : '0;
    sw_now         = (idx_q != last_served_q);

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (s_axis_tuser == rrs_pkg::CMD_LOAD) begin
            // A load while no set is open starts a fresh set.
            if (!load_open_q) begin
              mask_d         = '0;
              next_index_d   = '0;
              last_served_d  = '0;
              time_d         = '0;
              switch_count_d = '0;
            end
            job_count_d = base_count;
            if (base_count < CNT_W'(MAX_JOBS)) begin
              mem_we      = 1'b1;
              mem_waddr   = IDX_W'(base_count);
              mem_wdata   = {s_axis_tdata[rrs_pkg::BURST_W-1:0], rrs_pkg::SLICE_W'(0)};
              mask_d[IDX_W'(base_count)] = (s_axis_tdata[rrs_pkg::BURST_W-1:0] != '0);
              job_count_d = base_count + CNT_W'(1);
            end
            load_open_d = !s_axis_tlast;
          end else if (pick_found) begin
            idx_d   = pick_idx;
            mem_re  = 1'b1;
            state_d = ST_MUL;
          end else begin
            state_d = ST_EMPTY;
          end
        end
      end
      ST_MUL: begin
        sw_d = sw_now;
        if (sw_now) begin
          time_d = rrs_pkg::sat_add32(time_q, 32'(switch_cost_q));
          if (switch_count_q != '1) begin
            switch_count_d = switch_count_q + rrs_pkg::SLICE_W'(1);
          end
        end
        rem_d   = mem_rdata[rrs_pkg::ENTRY_W-1:rrs_pkg::SLICE_W];
        srv_d   = mem_rdata[rrs_pkg::SLICE_W-1:0];
        qeff_d  = (quantum_q == '0) ? rrs_pkg::CFG_W'(1) : quantum_q;
        parr_d  = PARR_W'(idx_q) * PARR_W'(spacing_q);
        psrv_d  = 32'(((quantum_q == '0) ? rrs_pkg::CFG_W'(1) : quantum_q))
                  * 32'(mem_rdata[rrs_pkg::SLICE_W-1:0]);
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          mem_we    = 1'b1;
          mem_waddr = idx_q;
          mem_wdata = {left, (!fin && srv_q != '1) ? srv_q + rrs_pkg::SLICE_W'(1) : srv_q};
          mask_d        = mask_after;
          time_d        = rrs_pkg::sat_add32(time_q, 32'(run));
          last_served_d = idx_q;
          next_index_d  = (idx_inc == job_count_q) ? '0 : IDX_W'(idx_inc);
          res_d.job_id       = id_ext[rrs_pkg::JOB_ID_W-1:0];
          res_d.cycles_left  = left;
          res_d.wait_time    = wait_sat;
          res_d.elapsed      = rrs_pkg::sat_add32(time_q, 32'(run));
          res_d.switched     = sw_q;
          res_d.finished     = fin;
          res_d.all_done     = ~|mask_after;
          res_d.switch_total = switch_count_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      ST_EMPTY: begin
        if (out_free) begin
          res_d.job_id       = '0;
          res_d.cycles_left  = '0;
          res_d.wait_time    = '0;
          res_d.elapsed      = time_q;
          res_d.switched     = 1'b0;
          res_d.finished     = 1'b0;
          res_d.all_done     = 1'b1;
          res_d.switch_total = switch_count_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      mask_q         <= '0;
      job_count_q    <= '0;
      next_index_q   <= '0;
      last_served_q  <= '0;
      time_q         <= '0;
      switch_count_q <= '0;
      load_open_q    <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      mask_q         <= mask_d;
      job_count_q    <= job_count_d;
      next_index_q   <= next_index_d;
      last_served_q  <= last_served_d;
      time_q         <= time_d;
      switch_count_q <= switch_count_d;
      load_open_q    <= load_open_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    rem_q  <= rem_d;
    srv_q  <= srv_d;
    qeff_q <= qeff_d;
    parr_q <= parr_d;
    psrv_q <= psrv_d;
    sw_q   <= sw_d;
    res_q  <= res_d;
  end

`ifndef NO_ASSERTIONS
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_count_q <= CNT_W'(MAX_JOBS))
    else $error("job count exceeds the table size");

  a_mask_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mask_q >> job_count_q) == '0)
    else $error("active job beyond the loaded count");

  a_next_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (job_count_q != '0) |-> (CNT_W'(next_index_q) < job_count_q))
    else $error("next index outside the loaded set");

  a_fin_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && !out_free) |=> (state_q == ST_FIN && $stable(idx_q)))
    else $error("slice write-back left while the output was full");

  a_result_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> ($past(state_q) == ST_FIN || $past(state_q) == ST_EMPTY))
    else $error("result item raised outside a result state");
`endif

endmodule

// ----- tb/rrs_slice_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the round-robin slice scheduler: tracks register writes, predicts each slice
// result from accepted items and compares it with the result stream. Depends on rrs_pkg.
module rrs_slice_checker
  import rrs_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                  s_axis_tuser,
  input  logic                  s_axis_tlast,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [OUT_DATA_W-1:0] m_axis_tdata,
  output int unsigned           mismatch_count,
  output int unsigned           pending_results
);

  localparam int unsigned JOBS = MAX_JOBS_DEF;
  localparam longint WAIT_MAX = 64'sd2147483647;
  localparam longint WAIT_MIN = -64'sd2147483648;

  logic [CFG_W-1:0]   quantum_q;
  logic [CFG_W-1:0]   switch_cost_q;
  logic [CFG_W-1:0]   spacing_q;

  logic [BURST_W-1:0] job_left   [JOBS];
  logic [SLICE_W-1:0] job_slices [JOBS];
  logic [JOBS-1:0]    job_active;
  int unsigned        job_count;
  int unsigned        next_job;
  int unsigned        last_job;
  logic [31:0]        time_now;
  logic [SLICE_W-1:0] switches;
  logic               set_open;
  int unsigned        results_seen;

  result_t expected_slices[$];

  function automatic logic [31:0] add_saturated(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  task automatic report_mismatch(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
    mismatch_count++;
    $display("%0t: result %0d, %s: expected %0h, got %0h",
             $time, results_seen, field, want, got);
  endtask

  // Applies one accepted item to the job table and, for a step, queues the result it produces.
  task automatic schedule_item(input logic cmd, input logic [BURST_W-1:0] burst,
                               input logic last);
    result_t     r;
    int unsigned k, c, pick, qeff, run;
    bit          found;
    longint      wait_l;
    logic [BURST_W-1:0] left;
    r = '0;
    found = 1'b0;
    pick = 0;
    if (cmd == CMD_LOAD) begin
      // A load outside an open set starts a fresh table and clock.
      if (!set_open) begin
        job_active = '0;
        job_count = 0;
        next_job = 0;
        last_job = 0;
        time_now = '0;
        switches = '0;
      end
      if (job_count < JOBS) begin
        job_left[job_count] = burst;
        job_slices[job_count] = '0;
        job_active[job_count] = (burst != '0);
        job_count++;
      end
      set_open = !last;
    end else begin
      for (k = 0; k < job_count; k++) begin
        c = (next_job + k) % job_count;
        if (!found && job_active[c]) begin
          pick = c;
          found = 1'b1;
        end
      end
      if (!found) begin
        r.elapsed = time_now;
        r.all_done = 1'b1;
        r.switch_total = switches;
      end else begin
        if (pick != last_job) begin
          r.switched = 1'b1;
          time_now = add_saturated(time_now, 32'(switch_cost_q));
          if (switches != '1) switches++;
        end
        qeff = (quantum_q == '0) ? 1 : int'(quantum_q);
        wait_l = longint'(time_now) - (longint'(pick) * longint'(spacing_q)
                 + longint'(qeff) * longint'(job_slices[pick]));
        if (wait_l > WAIT_MAX) wait_l = WAIT_MAX;
        if (wait_l < WAIT_MIN) wait_l = WAIT_MIN;
        left = job_left[pick];
        run = (left > qeff) ? qeff : int'(left);
        left = left - BURST_W'(run);
        job_left[pick] = left;
        time_now = add_saturated(time_now, 32'(run));
        if (left == '0) begin
          job_active[pick] = 1'b0;
          r.finished = 1'b1;
        end else if (job_slices[pick] != '1) begin
          job_slices[pick]++;
        end
        last_job = pick;
        next_job = (pick + 1) % job_count;
        r.job_id = JOB_ID_W'(pick + 1);
        r.cycles_left = left;
        r.wait_time = wait_l[31:0];
        r.elapsed = time_now;
        r.all_done = (job_active == '0);
        r.switch_total = switches;
      end
      expected_slices.push_back(r);
    end
  endtask

  task automatic check_slice(input logic [OUT_DATA_W-1:0] data);
    result_t got, want;
    got = result_t'(data[$bits(result_t)-1:0]);
    results_seen++;
    if (expected_slices.size() == 0) begin
      report_mismatch("result with no step waiting", '0, data[63:0]);
    end else begin
      want = expected_slices.pop_front();
      if (got.job_id !== want.job_id)
        report_mismatch("job_id", 64'(want.job_id), 64'(got.job_id));
      if (got.cycles_left !== want.cycles_left)
        report_mismatch("cycles_left", 64'(want.cycles_left), 64'(got.cycles_left));
      if (got.wait_time !== want.wait_time)
        report_mismatch("wait_time", 64'(want.wait_time), 64'(got.wait_time));
      if (got.elapsed !== want.elapsed)
        report_mismatch("elapsed", 64'(want.elapsed), 64'(got.elapsed));
      if (got.switched !== want.switched)
        report_mismatch("switched", 64'(want.switched), 64'(got.switched));
      if (got.finished !== want.finished)
        report_mismatch("finished", 64'(want.finished), 64'(got.finished));
      if (got.all_done !== want.all_done)
        report_mismatch("all_done", 64'(want.all_done), 64'(got.all_done));
      if (got.switch_total !== want.switch_total)
        report_mismatch("switch_total", 64'(want.switch_total), 64'(got.switch_total));
    end
    if (data[OUT_DATA_W-1:$bits(result_t)] !== '0)
      report_mismatch("padding", '0, 64'(data[OUT_DATA_W-1:$bits(result_t)]));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quantum_q = QUANTUM_RST;
      switch_cost_q = SWITCH_COST_RST;
      spacing_q = SPACING_RST;
      job_active = '0;
      job_count = 0;
      next_job = 0;
      last_job = 0;
      time_now = '0;
      switches = '0;
      set_open = 1'b0;
      results_seen = 0;
      mismatch_count = 0;
      expected_slices.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_QUANTUM:     quantum_q = cfg_wdata_i;
          CFG_SWITCH_COST: switch_cost_q = cfg_wdata_i;
          CFG_SPACING:     spacing_q = cfg_wdata_i;
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) check_slice(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready)
        schedule_item(s_axis_tuser, s_axis_tdata[BURST_W-1:0], s_axis_tlast);
    end
    pending_results = expected_slices.size();
  end

endmodule

// ----- tb/round_robin_slice_scheduler_tb.sv -----
`timescale 1ns / 1ps
// Top of the slice scheduler bench: clock, reset, register writes, item stimulus and verdict.
// Depends on rrs_pkg, round_robin_slice_scheduler and rrs_slice_checker.
module round_robin_slice_scheduler_tb;
  import rrs_pkg::*;

  localparam int unsigned SEGMENTS = 8;
  localparam int unsigned SEGMENT_ITEMS = 128;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES = 8;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_W-1:0]      cfg_wdata;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  s_tuser;
  logic                  s_tlast;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;

  int unsigned mismatch_count;
  int unsigned pending_results;
  int unsigned items_sent;
  int unsigned send_idle_pct;
  int unsigned stall_pct;
  int unsigned holds_requested;
  logic [CFG_W-1:0] cur_quantum;

  round_robin_slice_scheduler dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .s_axis_tlast  (s_tlast),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata)
  );

  rrs_slice_checker slice_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid   (s_tvalid),
    .s_axis_tready   (s_tready),
    .s_axis_tdata    (s_tdata),
    .s_axis_tuser    (s_tuser),
    .s_axis_tlast    (s_tlast),
    .m_axis_tvalid   (m_tvalid),
    .m_axis_tready   (m_tready),
    .m_axis_tdata    (m_tdata),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  initial begin
    #(2_000_000);
    $display("round_robin_slice_scheduler verification failed");
    $finish;
  end

  // Result side: random stalls, plus a long hold-off whenever one is requested so that the
  // output register fills and the input side backs up.
  initial begin : receiver
    int unsigned holds_done, hold_cycles;
    holds_done = 0;
    m_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (holds_requested != holds_done) begin
        holds_done++;
        for (hold_cycles = 0; hold_cycles < HOLD_CYCLES; hold_cycles++) begin
          m_tready <= 1'b0;
          @(posedge clk_i);
        end
      end
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic offer_item(input logic cmd, input logic [BURST_W-1:0] burst, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata <= burst;
    s_tuser <= cmd;
    s_tlast <= last;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    items_sent++;
  endtask

  // Waits until every slice has come back, then lets a trailing load settle.
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending_results != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_registers(input logic [CFG_W-1:0] q, input logic [CFG_W-1:0] cost,
                               input logic [CFG_W-1:0] spacing);
    drain();
    cfg_we <= 1'b1;
    cfg_idx <= CFG_QUANTUM;
    cfg_wdata <= q;
    @(posedge clk_i);
    cfg_idx <= CFG_SWITCH_COST;
    cfg_wdata <= cost;
    @(posedge clk_i);
    cfg_idx <= CFG_SPACING;
    cfg_wdata <= spacing;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
    cur_quantum = q;
  endtask

  // Bursts mostly span a few quanta so that jobs finish; some are empty or full width.
  function automatic logic [BURST_W-1:0] pick_burst();
    int unsigned roll, q;
    roll = $urandom_range(99);
    q = (cur_quantum == '0) ? 1 : int'(cur_quantum);
    if (roll < 8) return '0;
    if (roll < 14) return BURST_W'($urandom);
    return BURST_W'($urandom_range(4 * q, 1));
  endfunction

  task automatic run_set();
    int unsigned jobs, steps, j;
    bit close_set, step_midway;
    jobs = ($urandom_range(99) < 6) ? $urandom_range(70, 60) : $urandom_range(8, 1);
    close_set = ($urandom_range(99) < 85);
    step_midway = ($urandom_range(99) < 15);
    for (j = 0; j < jobs; j++) begin
      if (step_midway && j == jobs / 2)
        offer_item(CMD_STEP, BURST_W'($urandom), 1'($urandom));
      offer_item(CMD_LOAD, pick_burst(), close_set && (j == jobs - 1));
    end
    steps = jobs * 4 + $urandom_range(3, 0);
    for (j = 0; j < steps; j++) offer_item(CMD_STEP, BURST_W'($urandom), 1'($urandom));
  endtask

  initial begin
    int unsigned seg, target;
    logic [CFG_W-1:0] q, cost, spacing;
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_QUANTUM;
    cfg_wdata = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = CMD_LOAD;
    s_tlast = 1'b0;
    items_sent = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    holds_requested = 0;
    cur_quantum = QUANTUM_RST;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under the reset settings. A step on an empty table reports nothing left.
    offer_item(CMD_STEP, '0, 1'b0);
    offer_item(CMD_LOAD, '0, 1'b0);
    offer_item(CMD_LOAD, '1, 1'b0);
    // Stepping while the set is still open serves what is loaded so far.
    offer_item(CMD_STEP, '1, 1'b1);
    offer_item(CMD_LOAD, 24'd1, 1'b0);
    offer_item(CMD_LOAD, 24'd120, 1'b1);
    repeat (6) offer_item(CMD_STEP, '0, 1'b0);
    // A set holding only an empty job is done at once.
    offer_item(CMD_LOAD, '0, 1'b1);
    offer_item(CMD_STEP, '0, 1'b0);
    offer_item(CMD_LOAD, 24'd30, 1'b1);
    repeat (2) offer_item(CMD_STEP, '0, 1'b0);

    for (seg = 0; seg < SEGMENTS; seg++) begin
      case (seg)
        0: begin q = '0;  cost = '0;     spacing = '0;     end
        1: begin q = 16'd1; cost = '1;   spacing = '1;     end
        2: begin q = '1;  cost = 16'd1;  spacing = 16'd1;  end
        3: begin q = 16'd50; cost = 16'd10; spacing = 16'd50; end
        default: begin
          q = CFG_W'($urandom_range(300, 0));
          cost = CFG_W'($urandom);
          spacing = CFG_W'($urandom);
        end
      endcase
      set_registers(q, cost, spacing);
      case (seg % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 61; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 61; end
        default: begin send_idle_pct = 31; stall_pct = 31; end
      endcase
      if (seg % 4 == 0) holds_requested++;
      target = items_sent + SEGMENT_ITEMS;
      while (items_sent < target) begin
        if ($urandom_range(99) < 10)
          offer_item(1'($urandom), BURST_W'($urandom), 1'($urandom));
        else
          run_set();
      end
    end

    drain();
    if (mismatch_count == 0) begin
      $display("round_robin_slice_scheduler verification clean");
    end else begin
      $display("round_robin_slice_scheduler verification failed");
    end
    $finish;
  end

endmodule
